/* rtl/core/heightfield_triangle_height_query_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the heightfield triangle height query core
// Immediate-implication and next-cycle checks, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef HEIGHTFIELD_TRIANGLE_HEIGHT_QUERY_CORE_ASSERT_SVH
`define HEIGHTFIELD_TRIANGLE_HEIGHT_QUERY_CORE_ASSERT_SVH

// same-cycle check: ante |-> cons
`define HTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check: ante |=> cons
`define HTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/htq_pkg.sv */
// ---------------------------------------------------------------------------
// htq_pkg
// Types and constants of the heightfield triangle height query core.
// ---------------------------------------------------------------------------
package htq_pkg;

  localparam int unsigned STORE_AW    = 16;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned SIDE_W      = 9;
  localparam int unsigned MAX_SIDE    = 256;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned HEIGHT_W    = 13;
  localparam int unsigned ACC_W       = 33;

  // x / 10 == (x * 52429) >> 19, exact for x below 2^18
  localparam logic [16:0] RECIP_10    = 17'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH = 2'd1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // last step of the corner read/accumulate sweep
  localparam logic [2:0] READ_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] sample_index;
    logic [7:0]  sample_byte;
    logic [15:0] query_x;
    logic [15:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                out_of_grid;
  } out_item_t;

endpackage

/* rtl/core/heightfield_triangle_height_query_core.sv */
// ---------------------------------------------------------------------------
// heightfield_triangle_height_query_core
// 8-bit height grid with triangle-interpolated Q8.8 height lookup, over ten.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_ready  | in_item_t (write or query)
//  out_    | output    | out_valid/out_ready| out_item_t (height, off-grid)
//  cfg_    | input     | cfg_valid/cfg_ready| register index + 9-bit data
//
//  A sample write keeps the block in idle; it is ready again the next cycle.
//  An in-grid query steps through the address MAC, four corner reads through
//  the single-port sample RAM plus one drain, one reciprocal multiply and one
//  finish step; the next beat is taken in the cycle its result shows, never
//  before. An off-grid query goes straight from accept to the finish step.
//  All multiplies run through one shared 16x17 multiply-accumulate unit.
//  Synchronous active-low reset clears control and sets both grid sides to
//  256; the sample RAM is not cleared. A result held on a stalled out_ port
//  holds the next query in its finish step; no write is accepted meanwhile.
// ---------------------------------------------------------------------------

`include "heightfield_triangle_height_query_core_assert.svh"

module heightfield_triangle_height_query_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  htq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output htq_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htq_pkg::SIDE_W-1:0]     cfg_data
);

  localparam logic [htq_pkg::SIDE_W-1:0] SIDE_MAX = htq_pkg::SIDE_W'(htq_pkg::MAX_SIDE);

  // control
  htq_pkg::state_t state_r, state_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [htq_pkg::SIDE_W-1:0] grid_w_r, grid_d_r;

  // datapath
  logic [7:0]  col_r, col_nxt, row_r, row_nxt, u_r, u_nxt, v_r, v_nxt;
  logic        oog_r, oog_nxt;
  logic [15:0] base_r, base_nxt;
  logic [htq_pkg::ACC_W-1:0] acc_r, acc_nxt;
  htq_pkg::out_item_t out_r, out_nxt;

  // sample RAM
  logic [7:0]  store_r [htq_pkg::STORE_DEPTH];
  logic [7:0]  rdata_r;
  logic        mem_we;
  logic [15:0] mem_addr, rd_addr;

  // shared MAC
  logic [15:0] mac_a;
  logic [16:0] mac_b;
  logic [htq_pkg::ACC_W-1:0] mac_c, mac_prod, mac_sum;

  logic [htq_pkg::SIDE_W-1:0] w_eff, d_eff;
  logic        in_acc, in_oog;
  logic [8:0]  in_col_p1, in_row_p1;
  logic [9:0]  sum_uv;
  logic        upper;
  logic [8:0]  w00, w10, w01, w11, weight;
  logic [2:0]  cnt_m1;
  logic [1:0]  rd_corner, mac_corner;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == htq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_acc    = in_valid && in_ready;

  // oversized sides fold to the supported maximum
  assign w_eff = (grid_w_r > SIDE_MAX) ? SIDE_MAX : grid_w_r;
  assign d_eff = (grid_d_r > SIDE_MAX) ? SIDE_MAX : grid_d_r;

  // cell must have a right and a lower neighbor inside the grid
  assign in_col_p1 = {1'b0, in_data.query_x[15:8]} + 9'd1;
  assign in_row_p1 = {1'b0, in_data.query_z[15:8]} + 9'd1;
  assign in_oog    = (w_eff < 9'd2) || (d_eff < 9'd2) ||
                     (in_col_p1 >= w_eff) || (in_row_p1 >= d_eff);

  // triangle weights; corner code bit0 = col+1, bit1 = row+1
  assign sum_uv = {2'b00, u_r} + {2'b00, v_r};
  assign upper  = (sum_uv > 10'd256);
  assign w00 = upper ? 9'd0 : 9'(10'd256 - sum_uv);
  assign w10 = upper ? (9'd256 - {1'b0, v_r}) : {1'b0, u_r};
  assign w01 = upper ? (9'd256 - {1'b0, u_r}) : {1'b0, v_r};
  assign w11 = upper ? 9'(sum_uv - 10'd256) : 9'd0;

  assign cnt_m1     = cnt_r - 3'd1;
  assign rd_corner  = cnt_r[1:0];
  assign mac_corner = cnt_m1[1:0];

  always_comb begin
    case (mac_corner)
      2'd0:    weight = w00;
      2'd1:    weight = w10;
      2'd2:    weight = w01;
      default: weight = w11;
    endcase
  end

  assign rd_addr = base_r + (rd_corner[1] ? {7'd0, w_eff} : 16'd0) + {15'd0, rd_corner[0]};
  assign mem_we   = in_acc && (in_data.mode == htq_pkg::MODE_WRITE);
  assign mem_addr = mem_we ? in_data.sample_index : rd_addr;

  assign mac_prod = mac_a * mac_b;
  assign mac_sum  = mac_c + mac_prod;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    oog_nxt       = oog_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    mac_a         = 16'd0;
    mac_b         = 17'd0;
    mac_c         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      htq_pkg::ST_IDLE: begin
        if (in_acc && (in_data.mode == htq_pkg::MODE_QUERY)) begin
          col_nxt   = in_data.query_x[15:8];
          u_nxt     = in_data.query_x[7:0];
          row_nxt   = in_data.query_z[15:8];
          v_nxt     = in_data.query_z[7:0];
          oog_nxt   = in_oog;
          state_nxt = in_oog ? htq_pkg::ST_FIN : htq_pkg::ST_ADDR;
        end
      end
      htq_pkg::ST_ADDR: begin
        // base = row * width + col, wrapped to the store address width
        mac_a     = {8'd0, row_r};
        mac_b     = {8'd0, w_eff};
        mac_c     = {25'd0, col_r};
        base_nxt  = mac_sum[15:0];
        cnt_nxt   = 3'd0;
        state_nxt = htq_pkg::ST_READ;
      end
      htq_pkg::ST_READ: begin
        // read corner cnt, accumulate the corner read on the previous step
        mac_a = {8'd0, rdata_r};
        mac_b = {8'd0, weight};
        mac_c = (cnt_r == 3'd1) ? '0 : acc_r;
        if (cnt_r != 3'd0) begin
          acc_nxt = mac_sum;
        end
        if (cnt_r == htq_pkg::READ_LAST) begin
          state_nxt = htq_pkg::ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      htq_pkg::ST_DIV: begin
        mac_a     = acc_r[15:0];
        mac_b     = htq_pkg::RECIP_10;
        acc_nxt   = mac_sum;
        state_nxt = htq_pkg::ST_FIN;
      end
      htq_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.height      = oog_r ? '0 :
                                acc_r[htq_pkg::RECIP_SHIFT +: htq_pkg::HEIGHT_W];
          out_nxt.out_of_grid = oog_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = htq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = htq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htq_pkg::ST_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
      grid_w_r    <= htq_pkg::SIDE_W'(256);
      grid_d_r    <= htq_pkg::SIDE_W'(256);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == htq_pkg::REG_GRID_WIDTH) begin
          grid_w_r <= cfg_data;
        end else if (cfg_index == htq_pkg::REG_GRID_DEPTH) begin
          grid_d_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    oog_r  <= oog_nxt;
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  // single-port sample RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_addr] <= in_data.sample_byte;
    end else begin
      rdata_r <= store_r[mem_addr];
    end
  end

  // short names for the checks below
  logic is_idle, oog_shown, read_end, fin_go;
  assign is_idle   = (state_r == htq_pkg::ST_IDLE);
  assign oog_shown = out_valid_r && out_r.out_of_grid;
  assign read_end  = (state_r == htq_pkg::ST_READ) && (cnt_r == htq_pkg::READ_LAST);
  assign fin_go    = (state_r == htq_pkg::ST_FIN) && (!out_valid_r || out_ready);

  `HTQ_ASSERT_NOW(a_write_only_idle, clk, rst_n, mem_we, is_idle, "write outside idle")
  `HTQ_ASSERT_NOW(a_oog_zero, clk, rst_n, oog_shown, out_r.height == '0, "off-grid height not 0")
  `HTQ_ASSERT_NEXT(a_read_to_div, clk, rst_n, read_end, state_r == htq_pkg::ST_DIV, "no divide")
  `HTQ_ASSERT_NEXT(a_fin_delivers, clk, rst_n, fin_go, out_valid_r && is_idle, "result not shown")

endmodule
